/* rtl/tpu_pkg.sv */
// Package for the tracker pattern unpacker.
// Holds the parser phase codes, flag bits, pattern limits and the entry type.
// No dependencies.
package tpu_pkg;

  // Pattern geometry
  localparam int unsigned ROWS_PER_PATTERN = 64;
  localparam int unsigned MAX_CHANNELS     = 32;
  localparam int unsigned ROW_CNT_W        = $clog2(ROWS_PER_PATTERN + 1);
  localparam int unsigned ROW_W            = 6;
  localparam int unsigned CHAN_W           = 5;
  localparam int unsigned CHAN_CNT_W       = 6;

  // Parser phase codes
  localparam logic [2:0] PH_CTRL = 3'd0;
  localparam logic [2:0] PH_NOTE = 3'd1;
  localparam logic [2:0] PH_INST = 3'd2;
  localparam logic [2:0] PH_VOL  = 3'd3;
  localparam logic [2:0] PH_EFF  = 3'd4;
  localparam logic [2:0] PH_VAL  = 3'd5;

  // Bit positions within the entry flags (control byte bits 7..5)
  localparam int unsigned FL_NOTE = 0;
  localparam int unsigned FL_VOL  = 1;
  localparam int unsigned FL_CMD  = 2;

  // Defaults for absent fields
  localparam logic [7:0] VOLUME_DEFAULT = 8'hff;

  // One decoded entry
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [ROW_W-1:0]  row;
    logic [7:0]        note;
    logic [7:0]        instrument;
    logic [7:0]        volume;
    logic [7:0]        effect;
    logic [7:0]        fx_param;
  } entry_t;

  // 12*octave + semitone - 1, modulo 256
  function automatic logic [7:0] convert_note(input logic [7:0] b);
    logic [7:0] oct;
    oct = {4'd0, b[7:4]};
    return (oct << 3) + (oct << 2) + {4'd0, b[3:0]} - 8'd1;
  endfunction

endpackage

/* rtl/tpu_parser.sv */
// Packed pattern parser: phase, row and entry state plus the decode step.
// Depends on tpu_pkg.
module tpu_parser
  import tpu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  pattern_start_i,
  input  logic [CHAN_CNT_W-1:0] channel_count_i,
  output logic                  res_valid_o,
  output entry_t                res_o
);

  logic [2:0]           phase_q, phase_d;
  logic [ROW_CNT_W-1:0] row_q, row_d;
  logic [CHAN_W-1:0]    chan_q, chan_d;
  logic [2:0]           flags_q, flags_d;
  logic [7:0]           note_q, note_d;
  logic [7:0]           inst_q, inst_d;
  logic [7:0]           vol_q, vol_d;
  logic [7:0]           eff_q, eff_d;

  logic [2:0]           phase_cur;
  logic [ROW_CNT_W-1:0] row_cur;
  logic                 done;
  logic                 finish;
  logic [7:0]           value;

  // Decode one byte
  always_comb begin
    phase_cur = pattern_start_i ? PH_CTRL : phase_q;
    row_cur   = pattern_start_i ? '0 : row_q;
    done      = (row_cur >= ROW_CNT_W'(ROWS_PER_PATTERN));
    phase_d   = phase_cur;
    row_d     = row_cur;
    chan_d    = chan_q;
    flags_d   = flags_q;
    note_d    = note_q;
    inst_d    = inst_q;
    vol_d     = vol_q;
    eff_d     = eff_q;
    finish    = 1'b0;
    value     = 8'd0;

    if (!done) begin
      unique case (phase_cur)
        PH_CTRL: begin
          if (data_byte_i == 8'd0) begin
            row_d = row_cur + ROW_CNT_W'(1);
          end else begin
            chan_d  = data_byte_i[4:0];
            flags_d = data_byte_i[7:5];
            note_d  = 8'd0;
            inst_d  = 8'd0;
            vol_d   = VOLUME_DEFAULT;
            eff_d   = 8'd0;
            if (data_byte_i[5+FL_NOTE]) phase_d = PH_NOTE;
            else if (data_byte_i[5+FL_VOL]) phase_d = PH_VOL;
            else if (data_byte_i[5+FL_CMD]) phase_d = PH_EFF;
            else finish = 1'b1;
          end
        end
        PH_NOTE: begin
          note_d  = convert_note(data_byte_i);
          phase_d = PH_INST;
        end
        PH_INST: begin
          inst_d = data_byte_i;
          if (flags_q[FL_VOL]) phase_d = PH_VOL;
          else if (flags_q[FL_CMD]) phase_d = PH_EFF;
          else finish = 1'b1;
        end
        PH_VOL: begin
          vol_d = data_byte_i;
          if (flags_q[FL_CMD]) phase_d = PH_EFF;
          else finish = 1'b1;
        end
        PH_EFF: begin
          eff_d   = data_byte_i;
          phase_d = PH_VAL;
        end
        PH_VAL: begin
          value  = data_byte_i;
          finish = 1'b1;
        end
        default: phase_d = PH_CTRL;
      endcase
      if (finish) phase_d = PH_CTRL;
    end
  end

  // Entries at or above the channel count are dropped
  assign res_valid_o = finish && ({1'b0, chan_d} < channel_count_i);

  assign res_o = '{channel:    chan_d,
                   row:        row_cur[ROW_W-1:0],
                   note:       note_d,
                   instrument: inst_d,
                   volume:     vol_d,
                   effect:     eff_d,
                   fx_param:   value};

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      row_q   <= '0;
      chan_q  <= '0;
      flags_q <= '0;
      note_q  <= 8'd0;
      inst_q  <= 8'd0;
      vol_q   <= VOLUME_DEFAULT;
      eff_q   <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      chan_q  <= chan_d;
      flags_q <= flags_d;
      note_q  <= note_d;
      inst_q  <= inst_d;
      vol_q   <= vol_d;
      eff_q   <= eff_d;
    end
  end

endmodule

/* rtl/tracker_pattern_unpacker_core.sv */
// Top level of the tracker pattern unpacker: input register, parser, result register.
// Depends on tpu_pkg and tpu_parser.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o) carries one byte of the packed
//   pattern stream per transfer, with pattern_start_i marking the first byte
//   of a pattern. Output channel (out_valid_o / out_ready_i) carries one
//   decoded entry per transfer; bytes that end rows, carry entry data before
//   its last byte, belong to dropped channels or follow the last row give none.
// - A byte passes from the input register through the parser into the
//   result register; a stalled result register holds it back.
// - Throughput: one byte per cycle while the receiver does not stall; the parser is combinational.
// - When the receiver stalls with an entry held, the byte in the input
//   register waits and the input channel takes no further byte.
// - Reset clears the valid flags of both registers, resets the parser state and sets channel_count to 32.
// - cfg_we_i writes channel_count from cfg_wdata_i; write it only while idle.
module tracker_pattern_unpacker_core
  import tpu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CHAN_CNT_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  pattern_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAN_W-1:0]     channel_o,
  output logic [ROW_W-1:0]      row_o,
  output logic [7:0]            note_o,
  output logic [7:0]            instrument_o,
  output logic [7:0]            volume_o,
  output logic [7:0]            effect_o,
  output logic [7:0]            fx_param_o
);

  logic [CHAN_CNT_W-1:0] chan_count_q;
  logic                  in_valid_q;
  logic [7:0]            byte_q;
  logic                  start_q;
  logic                  out_valid_q;
  entry_t                out_q;
  logic                  advance;
  logic                  res_valid;
  entry_t                res;

  // Held byte moves on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= CHAN_CNT_W'(MAX_CHANNELS);
    end else if (cfg_we_i) begin
      chan_count_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= data_byte_i;
      start_q <= pattern_start_i;
    end
  end

  tpu_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .data_byte_i     (byte_q),
    .pattern_start_i (start_q),
    .channel_count_i (chan_count_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign channel_o    = out_q.channel;
  assign row_o        = out_q.row;
  assign note_o       = out_q.note;
  assign instrument_o = out_q.instrument;
  assign volume_o     = out_q.volume;
  assign effect_o     = out_q.effect;
  assign fx_param_o   = out_q.fx_param;

endmodule

/* verif/tpu_entry_checker.sv */
`timescale 1ns / 1ps
// Entry checker for tracker_pattern_unpacker_core: follows byte and result transfers
// and channel_count writes, predicts each decoded entry and compares it field by field.
// Depends on tpu_pkg.
module tpu_entry_checker
  import tpu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CHAN_CNT_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  pattern_start_i,
  input  logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [CHAN_W-1:0]     channel_o,
  input  logic [ROW_W-1:0]      row_o,
  input  logic [7:0]            note_o,
  input  logic [7:0]            instrument_o,
  input  logic [7:0]            volume_o,
  input  logic [7:0]            effect_o,
  input  logic [7:0]            fx_param_o,
  output int unsigned           mismatch_count_o,
  output int unsigned           entries_pending_o
);

  // Shadow of the parser state and the channel_count register
  logic [CHAN_CNT_W-1:0] chan_limit;
  logic [2:0]            parse_ph;
  logic [6:0]            row_cnt;
  logic [4:0]            cur_chan;
  logic [2:0]            cur_flags;
  logic [7:0]            note_q;
  logic [7:0]            inst_q;
  logic [7:0]            vol_q;
  logic [7:0]            eff_q;

  entry_t entries_q[$];

  // Phase that follows once the field at phase 'done' has been taken
  function automatic logic [2:0] phase_after(input logic [2:0] done);
    if (done < PH_VOL && cur_flags[FL_VOL]) return PH_VOL;
    if (done < PH_EFF && cur_flags[FL_CMD]) return PH_EFF;
    return PH_CTRL;
  endfunction

  // Entry complete: builds the result unless the channel is dropped
  function automatic bit close_entry(input logic [7:0] value, output entry_t ent);
    ent = '0;
    parse_ph = PH_CTRL;
    if ({1'b0, cur_chan} >= chan_limit) return 1'b0;
    ent.channel    = cur_chan;
    ent.row        = row_cnt[ROW_W-1:0];
    ent.note       = note_q;
    ent.instrument = inst_q;
    ent.volume     = vol_q;
    ent.effect     = eff_q;
    ent.fx_param   = value;
    return 1'b1;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when an entry comes out
  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output entry_t ent);
    logic [2:0]  nxt;
    int unsigned semis;
    ent = '0;
    if (start) begin
      parse_ph = PH_CTRL;
      row_cnt  = '0;
    end
    if (row_cnt >= ROWS_PER_PATTERN) return 1'b0;
    case (parse_ph)
      PH_CTRL: begin
        if (b == 8'd0) begin
          row_cnt = row_cnt + 7'd1;
          return 1'b0;
        end
        cur_chan  = b[4:0];
        cur_flags = b[7:5];
        note_q    = 8'd0;
        inst_q    = 8'd0;
        vol_q     = VOLUME_DEFAULT;
        eff_q     = 8'd0;
        if (cur_flags[FL_NOTE]) begin
          parse_ph = PH_NOTE;
          return 1'b0;
        end
        nxt = phase_after(PH_INST);
        if (nxt == PH_CTRL) return close_entry(8'd0, ent);
        parse_ph = nxt;
        return 1'b0;
      end
      PH_NOTE: begin
        // octave in the high nibble, semitone in the low one
        semis    = 12 * int'(b[7:4]) + int'(b[3:0]) - 1;
        note_q   = semis[7:0];
        parse_ph = PH_INST;
        return 1'b0;
      end
      PH_INST: begin
        inst_q = b;
        nxt    = phase_after(PH_INST);
        if (nxt == PH_CTRL) return close_entry(8'd0, ent);
        parse_ph = nxt;
        return 1'b0;
      end
      PH_VOL: begin
        vol_q = b;
        nxt   = phase_after(PH_VOL);
        if (nxt == PH_CTRL) return close_entry(8'd0, ent);
        parse_ph = nxt;
        return 1'b0;
      end
      PH_EFF: begin
        eff_q    = b;
        parse_ph = PH_VAL;
        return 1'b0;
      end
      PH_VAL: begin
        return close_entry(b, ent);
      end
      default: begin
        parse_ph = PH_CTRL;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count_o++;
    end
  endtask

  // Result transfers are checked before byte transfers of the same edge,
  // so a fresh prediction never meets a result that is older than it
  always @(posedge clk_i or negedge rst_ni) begin
    entry_t want;
    entry_t ent;
    if (!rst_ni) begin
      chan_limit        = 6'd32;
      parse_ph          = PH_CTRL;
      row_cnt           = '0;
      cur_chan          = '0;
      cur_flags         = '0;
      note_q            = 8'd0;
      inst_q            = 8'd0;
      vol_q             = VOLUME_DEFAULT;
      eff_q             = 8'd0;
      mismatch_count_o  = 0;
      entries_pending_o = 0;
      entries_q.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (entries_q.size() == 0) begin
          $display("%0t: unexpected entry, expected none, actual channel %0d row %0d",
                   $time, channel_o, row_o);
          mismatch_count_o++;
        end else begin
          want = entries_q.pop_front();
          check_field("channel", want.channel, channel_o);
          check_field("row", want.row, row_o);
          check_field("note", want.note, note_o);
          check_field("instrument", want.instrument, instrument_o);
          check_field("volume", want.volume, volume_o);
          check_field("effect", want.effect, effect_o);
          check_field("fx_param", want.fx_param, fx_param_o);
        end
      end
      if (cfg_we_i) chan_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        if (decode_byte(data_byte_i, pattern_start_i, ent)) entries_q = {entries_q, ent};
      end
      entries_pending_o = entries_q.size();
    end
  end

endmodule

/* verif/tb_tracker_pattern_unpacker_core.sv */
`timescale 1ns / 1ps
// Testbench top for tracker_pattern_unpacker_core: drives packed pattern streams
// and channel_count settings with random idling, and gives the verdict.
// Depends on tpu_pkg, tracker_pattern_unpacker_core and tpu_entry_checker.
module tb_tracker_pattern_unpacker_core;
  import tpu_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1850;
  localparam int unsigned SETTINGS_CNT = 5;
  localparam int unsigned SETTLE_CYC   = 4;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CHAN_CNT_W-1:0] cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic [7:0]            data_byte_i     = 8'd0;
  logic                  pattern_start_i = 1'b0;
  logic                  out_ready_i     = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [CHAN_W-1:0]     channel_o;
  logic [ROW_W-1:0]      row_o;
  logic [7:0]            note_o;
  logic [7:0]            instrument_o;
  logic [7:0]            volume_o;
  logic [7:0]            effect_o;
  logic [7:0]            fx_param_o;
  int unsigned           mismatches;
  int unsigned           entries_pending;

  int unsigned bytes_sent    = 0;
  bit          start_pending = 1'b0;
  bit          no_gaps       = 1'b0;

  tracker_pattern_unpacker_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .pattern_start_i(pattern_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_o      (channel_o),
    .row_o          (row_o),
    .note_o         (note_o),
    .instrument_o   (instrument_o),
    .volume_o       (volume_o),
    .effect_o       (effect_o),
    .fx_param_o     (fx_param_o)
  );

  tpu_entry_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .pattern_start_i  (pattern_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .channel_o        (channel_o),
    .row_o            (row_o),
    .note_o           (note_o),
    .instrument_o     (instrument_o),
    .volume_o         (volume_o),
    .effect_o         (effect_o),
    .fx_param_o       (fx_param_o),
    .mismatch_count_o (mismatches),
    .entries_pending_o(entries_pending)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Idle cycles before one transfer; none during back-to-back stretches
  function automatic int unsigned draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Data byte with extra weight on zero and all-ones
  function automatic logic [7:0] data_value();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    pattern_start_i <= start_pending;
    start_pending    = 1'b0;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Stops the stream and waits out every expected entry plus the pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    while (entries_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_channel_count(input logic [CHAN_CNT_W-1:0] count);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Control byte plus the field bytes that its flags call for
  task automatic send_entry();
    logic [4:0] chan;
    logic [2:0] flags;
    logic [7:0] note;
    flags = 3'($urandom_range(0, 7));
    chan  = $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    if (flags == 3'd0 && chan == 5'd0) chan = 5'($urandom_range(1, 31));
    send_byte({flags, chan});
    if (flags[FL_NOTE]) begin
      note = data_value();
      if ($urandom_range(0, 7) == 0) note = 8'hfe | 8'($urandom_range(0, 1));
      send_byte(note);
      send_byte(data_value());
    end
    if (flags[FL_VOL]) send_byte(data_value());
    if (flags[FL_CMD]) begin
      send_byte(data_value());
      send_byte(data_value());
    end
  endtask

  // One pattern: rows of entries, each row closed by a zero byte. Full
  // patterns run past the last row so that trailing bytes get ignored.
  task automatic send_pattern(input int unsigned quota);
    int unsigned rows;
    int unsigned density;
    int unsigned n;
    rows = ($urandom_range(0, 2) != 0) ? ROWS_PER_PATTERN + $urandom_range(0, 2)
                                       : $urandom_range(1, ROWS_PER_PATTERN - 1);
    density       = $urandom_range(0, 3);
    start_pending = 1'b1;
    for (int unsigned r = 0; r < rows && bytes_sent < quota; r++) begin
      n = ($urandom_range(0, 3) < density) ? $urandom_range(1, 3) : 0;
      for (int unsigned k = 0; k < n; k++) begin
        // noise: a stray byte, now and then restarting the pattern
        if ($urandom_range(0, 39) == 0) begin
          if ($urandom_range(0, 3) == 0) start_pending = 1'b1;
          send_byte(8'($urandom_range(0, 255)));
        end
        send_entry();
      end
      send_byte(8'h00);
    end
    if (rows >= ROWS_PER_PATTERN) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stall before each transfer
  initial begin : receiver
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [CHAN_CNT_W-1:0] count;
    int unsigned           quota;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme field values, single fields, all fields, volume + command, zero as data
    start_pending = 1'b1;
    send_byte(8'h20);                                  // ch 0, note + instrument
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);                                  // ch 31, every field
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h05);                                  // empty control byte
    send_byte(8'h00);                                  // row end
    send_byte(8'h43);                                  // volume only
    send_byte(8'h80);
    send_byte(8'h87);                                  // command only
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h3e);                                  // note byte 254
    send_byte(8'hfe);
    send_byte(8'h7f);
    send_byte(8'hc1);                                  // volume + command
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h00);

    // Random patterns under several channel counts, extremes among them
    for (int unsigned s = 0; s < SETTINGS_CNT; s++) begin
      case (s)
        0:       count = 6'd32;
        1:       count = 6'd0;
        2:       count = 6'd63;
        3:       count = 6'd1;
        default: count = 6'($urandom_range(2, 31));
      endcase
      write_channel_count(count);
      quota = bytes_sent + RANDOM_BYTES / SETTINGS_CNT;
      while (bytes_sent < quota) begin
        no_gaps = ($urandom_range(0, 4) == 0);
        send_pattern(quota);
      end
    end
    no_gaps = 1'b0;

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && entries_pending == 0) begin
      $display("tracker_pattern_unpacker_core test passed");
    end else begin
      $display("tracker_pattern_unpacker_core test failed");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #5_000_000;
    $display("tracker_pattern_unpacker_core test failed");
    $finish;
  end

endmodule

/* files.f */
rtl/tpu_pkg.sv
rtl/tpu_parser.sv
rtl/tracker_pattern_unpacker_core.sv
verif/tpu_entry_checker.sv
verif/tb_tracker_pattern_unpacker_core.sv
